[rtl/core/pcws_pkg.sv]
// ----------------------------------------------------------------------------
// pcws_pkg: shared types and constants of the prefix and CRC-32 window search
// Holds register indexes, the inter-module request types and the CRC update.
// ----------------------------------------------------------------------------
`default_nettype none
package pcws_pkg;

  localparam int IDX_W = 16;

  localparam logic [2:0] REG_START_ADDRESS = 3'd0;
  localparam logic [2:0] REG_BODY_LENGTH   = 3'd1;
  localparam logic [2:0] REG_PREFIX_LENGTH = 3'd2;
  localparam logic [2:0] REG_PREFIX_LOW    = 3'd3;
  localparam logic [2:0] REG_PREFIX_HIGH   = 3'd4;
  localparam logic [2:0] REG_TARGET_CRC    = 3'd5;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  // A request from the front to the back: a window to verify, or a plain
  // not-found report.
  typedef struct packed {
    logic              cand;
    logic [IDX_W-1:0]  start_idx;
    logic [31:0]       addr;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic valid;
    logic match;
  } verdict_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/core/pcws_queue.sv]
// ----------------------------------------------------------------------------
// pcws_queue: two-entry request queue between front and back
// Lets the front hand over a request while the back is still busy.
// ----------------------------------------------------------------------------
`default_nettype none
module pcws_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire pcws_pkg::job_t  push_data,
  input  wire logic            pop,
  output pcws_pkg::job_t       pop_data,
  output logic                 full,
  output logic                 empty
);
  import pcws_pkg::*;

  job_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push && !full) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop && !empty) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if ((push && !full) && !(pop && !empty)) begin
      count_nxt = count_r + 2'd1;
    end else if (!(push && !full) && (pop && !empty)) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

[rtl/core/pcws_front.sv]
// ----------------------------------------------------------------------------
// pcws_front: byte intake and window classification
// Stores each byte while the scan runs, tracks the scan position and the latest unmapped byte,
// and hands windows that pass the cheap checks, and not-found reports, to the back.
// ----------------------------------------------------------------------------
`default_nettype none
module pcws_front #(
  parameter int MAX_BODY   = 4096,
  parameter int MAX_PREFIX = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_mapped,
  input  wire logic               in_last_byte,
  input  wire logic [31:0]        start_address,
  input  wire logic [12:0]        body_length,
  input  wire logic [4:0]         prefix_length,
  input  wire logic               rearm,
  output logic                    q_push,
  output pcws_pkg::job_t          q_data,
  input  wire logic               q_full,
  input  wire pcws_pkg::verdict_t verdict,
  output pcws_pkg::mem_wr_t       mem_wr
);
  import pcws_pkg::*;

  localparam int AW = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_BODY - 1);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_WAIT = 2'b10
  } fstate_t;

  fstate_t       state_r, state_nxt;
  logic [31:0]   seen_r, seen_nxt;
  logic          done_r, done_nxt;
  logic          unm_v_r, unm_v_nxt;
  logic [31:0]   unm_pos_r, unm_pos_nxt;
  logic [AW-1:0] wr_idx_r, wr_idx_nxt;
  logic          last_l_r, last_l_nxt;
  logic          done_before_r, done_before_nxt;

  logic          accept, examine, body_ok, complete, unm_clear, addr_ok, pre_ok, cand;
  logic [31:0]   body32, first;
  logic [32:0]   addr_sum;
  logic [31:0]   idx_diff;

  assign in_ready = (state_r == F_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;

  assign body32    = {19'd0, body_length};
  assign examine   = !done_r && (seen_r != 32'hFFFFFFFF);
  assign body_ok   = (body_length != 13'd0) && (body32 <= 32'(MAX_BODY));
  assign complete  = seen_r >= (body32 - 32'd1);
  assign first     = seen_r - (body32 - 32'd1);
  assign unm_clear = in_mapped && (!unm_v_r || (unm_pos_r < first));
  assign addr_sum  = {1'b0, start_address} + {1'b0, seen_r};
  assign addr_ok   = !addr_sum[32];
  assign pre_ok    = (prefix_length != 5'd0) && ({27'd0, prefix_length} <= 32'(MAX_PREFIX))
                     && ({8'd0, prefix_length} <= body_length);
  assign cand      = examine && body_ok && complete && unm_clear && addr_ok && pre_ok;

  // Store index of the window's first byte, modulo the store depth.
  always_comb begin
    if ({{(32-AW){1'b0}}, wr_idx_r} >= (body32 - 32'd1)) begin
      idx_diff = {{(32-AW){1'b0}}, wr_idx_r} - (body32 - 32'd1);
    end else begin
      idx_diff = {{(32-AW){1'b0}}, wr_idx_r} + 32'(MAX_BODY) - (body32 - 32'd1);
    end
  end

  always_comb begin
    state_nxt       = state_r;
    seen_nxt        = seen_r;
    done_nxt        = done_r;
    unm_v_nxt       = unm_v_r;
    unm_pos_nxt     = unm_pos_r;
    wr_idx_nxt      = wr_idx_r;
    last_l_nxt      = last_l_r;
    done_before_nxt = done_before_r;
    q_push          = 1'b0;
    q_data          = '0;
    mem_wr          = '0;

    case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (examine && body_ok) begin
            mem_wr.en   = 1'b1;
            mem_wr.idx  = IDX_W'(wr_idx_r);
            mem_wr.data = in_data_byte;
            wr_idx_nxt  = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + 1'b1;
            if (!in_mapped) begin
              unm_v_nxt   = 1'b1;
              unm_pos_nxt = seen_r;
            end
          end
          if (examine) begin
            seen_nxt = seen_r + 32'd1;
          end
          if (cand) begin
            q_push           = 1'b1;
            q_data.cand      = 1'b1;
            q_data.start_idx = IDX_W'(idx_diff[AW-1:0]);
            q_data.addr      = start_address + first;
            last_l_nxt       = in_last_byte;
            done_before_nxt  = done_r;
            state_nxt        = F_WAIT;
          end else if (in_last_byte) begin
            if (!done_r) begin
              q_push = 1'b1;
            end
            seen_nxt   = '0;
            unm_v_nxt  = 1'b0;
            done_nxt   = 1'b0;
            wr_idx_nxt = '0;
          end
        end
      end
      F_WAIT: begin
        if (verdict.valid) begin
          state_nxt = F_IDLE;
          if (verdict.match) begin
            done_nxt = 1'b1;
          end
          if (last_l_r) begin
            if (!done_before_r && !verdict.match) begin
              q_push = 1'b1;
            end
            seen_nxt   = '0;
            unm_v_nxt  = 1'b0;
            done_nxt   = 1'b0;
            wr_idx_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase

    if (rearm) begin
      seen_nxt   = '0;
      unm_v_nxt  = 1'b0;
      done_nxt   = 1'b0;
      wr_idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      seen_r   <= '0;
      done_r   <= 1'b0;
      unm_v_r  <= 1'b0;
      wr_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      seen_r   <= seen_nxt;
      done_r   <= done_nxt;
      unm_v_r  <= unm_v_nxt;
      wr_idx_r <= wr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unm_pos_r     <= unm_pos_nxt;
    last_l_r      <= last_l_nxt;
    done_before_r <= done_before_nxt;
  end

endmodule
`default_nettype wire

[rtl/core/pcws_back.sv]
// ----------------------------------------------------------------------------
// pcws_back: window verification and result output
// Walks a window in the byte store, checks the prefix and runs the CRC-32,
// and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module pcws_back #(
  parameter int MAX_BODY = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pcws_pkg::mem_wr_t mem_wr,
  input  wire pcws_pkg::job_t    q_data,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output pcws_pkg::verdict_t     verdict,
  input  wire logic [12:0]       body_length,
  input  wire logic [4:0]        prefix_length,
  input  wire logic [63:0]       prefix_low,
  input  wire logic [63:0]       prefix_high,
  input  wire logic [31:0]       target_crc,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_found,
  output logic [31:0]            out_match_address
);
  import pcws_pkg::*;

  localparam int AW = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_BODY - 1);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_CALC = 3'b100
  } bstate_t;

  logic [7:0]    mem [MAX_BODY];
  logic [7:0]    rd_data_r;

  bstate_t       state_r, state_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [12:0]   cnt_r, cnt_nxt;
  logic [31:0]   crc_r, crc_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          found_r, found_nxt;
  logic [31:0]   maddr_r, maddr_nxt;

  logic [127:0]  pfx;
  logic [7:0]    pfx_byte;
  logic [31:0]   crc_new;
  logic          pfail;

  assign out_valid         = out_valid_r;
  assign out_found         = found_r;
  assign out_match_address = maddr_r;

  assign pfx      = {prefix_high, prefix_low};
  assign pfx_byte = pfx[{cnt_r[3:0], 3'b000} +: 8];
  assign pfail    = (cnt_r < {8'd0, prefix_length}) && (rd_data_r != pfx_byte);
  assign crc_new  = crc_byte(crc_r, rd_data_r);

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.idx[AW-1:0]] <= mem_wr.data;
    end
    rd_data_r <= mem[rd_idx_r];
  end

  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    cnt_nxt       = cnt_r;
    crc_nxt       = crc_r;
    addr_nxt      = addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    found_nxt     = found_r;
    maddr_nxt     = maddr_r;
    q_pop         = 1'b0;
    verdict       = '0;

    case (state_r)
      B_IDLE: begin
        // A request is taken only with the output register free, so the
        // result it makes always has a place to go.
        if (!q_empty && !out_valid_r) begin
          q_pop = 1'b1;
          if (q_data.cand) begin
            rd_idx_nxt = q_data.start_idx[AW-1:0];
            cnt_nxt    = '0;
            crc_nxt    = 32'hFFFFFFFF;
            addr_nxt   = q_data.addr;
            state_nxt  = B_READ;
          end else begin
            out_valid_nxt = 1'b1;
            found_nxt     = 1'b0;
            maddr_nxt     = '0;
          end
        end
      end
      B_READ: begin
        state_nxt = B_CALC;
      end
      B_CALC: begin
        crc_nxt = crc_new;
        if (pfail) begin
          verdict.valid = 1'b1;
          state_nxt     = B_IDLE;
        end else if (cnt_r == body_length - 13'd1) begin
          verdict.valid = 1'b1;
          verdict.match = (~crc_new) == target_crc;
          state_nxt     = B_IDLE;
          if ((~crc_new) == target_crc) begin
            out_valid_nxt = 1'b1;
            found_nxt     = 1'b1;
            maddr_nxt     = addr_r;
          end
        end else begin
          cnt_nxt    = cnt_r + 13'd1;
          rd_idx_nxt = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;
          state_nxt  = B_READ;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    cnt_r    <= cnt_nxt;
    crc_r    <= crc_nxt;
    addr_r   <= addr_nxt;
    found_r  <= found_nxt;
    maddr_r  <= maddr_nxt;
  end

endmodule
`default_nettype wire

[rtl/core/prefix_and_crc32_window_search_unit.sv]
// A byte whose window fails the cheap checks does not hold the intake; a candidate
// window holds it until the verdict. The back walks the window byte by byte, a store
// read state then a CRC state per byte on the single read port, until a prefix
// mismatch or the full CRC pass; it starts only once an earlier result has left the
// output register. A not-found result goes via the queue; a found one with the verdict.
// Reset clears the scan position, flags and registers; the byte store is not cleared.
// ----------------------------------------------------------------------------
// prefix_and_crc32_window_search_unit: prefix and CRC-32 window search
// Configuration registers, intake front, request queue and verifying back.
// ----------------------------------------------------------------------------
`default_nettype none
module prefix_and_crc32_window_search_unit #(
  parameter int MAX_BODY   = 4096,
  parameter int MAX_PREFIX = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_mapped,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_found,
  output logic [31:0]      out_match_address,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import pcws_pkg::*;

  logic [31:0] start_address_r;
  logic [12:0] body_length_r;
  logic [4:0]  prefix_length_r;
  logic [63:0] prefix_low_r;
  logic [63:0] prefix_high_r;
  logic [31:0] target_crc_r;
  logic        rearm;

  logic        q_push, q_pop, q_full, q_empty;
  job_t        q_in, q_out;
  verdict_t    verdict;
  mem_wr_t     mem_wr;

  assign cfg_ready = 1'b1;
  assign rearm = cfg_valid && (cfg_index == REG_START_ADDRESS || cfg_index == REG_BODY_LENGTH
                 || cfg_index == REG_PREFIX_LENGTH || cfg_index == REG_PREFIX_LOW
                 || cfg_index == REG_PREFIX_HIGH || cfg_index == REG_TARGET_CRC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_address_r <= '0;
      body_length_r   <= 13'd1;
      prefix_length_r <= 5'd1;
      prefix_low_r    <= '0;
      prefix_high_r   <= '0;
      target_crc_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_ADDRESS: start_address_r <= cfg_data[31:0];
        REG_BODY_LENGTH:   body_length_r   <= cfg_data[12:0];
        REG_PREFIX_LENGTH: prefix_length_r <= cfg_data[4:0];
        REG_PREFIX_LOW:    prefix_low_r    <= cfg_data;
        REG_PREFIX_HIGH:   prefix_high_r   <= cfg_data;
        REG_TARGET_CRC:    target_crc_r    <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  pcws_front #(
    .MAX_BODY   (MAX_BODY),
    .MAX_PREFIX (MAX_PREFIX)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_mapped     (in_mapped),
    .in_last_byte  (in_last_byte),
    .start_address (start_address_r),
    .body_length   (body_length_r),
    .prefix_length (prefix_length_r),
    .rearm         (rearm),
    .q_push        (q_push),
    .q_data        (q_in),
    .q_full        (q_full),
    .verdict       (verdict),
    .mem_wr        (mem_wr)
  );

  pcws_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  pcws_back #(
    .MAX_BODY (MAX_BODY)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .mem_wr            (mem_wr),
    .q_data            (q_out),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .verdict           (verdict),
    .body_length       (body_length_r),
    .prefix_length     (prefix_length_r),
    .prefix_low        (prefix_low_r),
    .prefix_high       (prefix_high_r),
    .target_crc        (target_crc_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_match_address (out_match_address)
  );

endmodule
`default_nettype wire

[dv/prefix_and_crc32_window_search_unit_tb.sv]
// ----------------------------------------------------------------------------
// prefix_and_crc32_window_search_unit_tb: self-checking bench for the search
// Streams byte regions through the unit under several register settings. A
// local model tracks the scan, predicts each found or not-found report and
// compares it with what the unit returns, under random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module prefix_and_crc32_window_search_unit_tb;
  import pcws_pkg::*;

  localparam int MAXB = 4096;
  localparam int WD_LIMIT = 60000;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       mapped;
    logic       last;
  } byte_req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] addr;
  } report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_data_byte = '0;
  logic in_mapped = 1'b0;
  logic in_last_byte = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  wire in_ready, out_valid, out_found, cfg_ready;
  wire [31:0] out_match_address;

  prefix_and_crc32_window_search_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data_byte(in_data_byte),
    .in_mapped(in_mapped), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_found(out_found),
    .out_match_address(out_match_address),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model state.
  logic [31:0] m_start;
  logic [12:0] m_body;
  logic [4:0]  m_plen;
  logic [63:0] m_plo, m_phi;
  logic [31:0] m_crc;
  logic [8:0]  m_store [MAXB];
  logic [31:0] m_seen;
  int unsigned m_unmapped;
  bit          m_done;

  byte_req_t pending_bytes[$];
  report_t   expected_reports[$];
  int errors = 0, bytes_sent = 0, reports_seen = 0, found_seen = 0;
  int idle_pct = 20;
  bit hold_out = 1'b0;
  int watchdog = 0;
  logic in_ready_q = 1'b0;

  function automatic logic [7:0] prefix_at(int i);
    if (i < 8) return m_plo[8*i +: 8];
    return m_phi[8*(i-8) +: 8];
  endfunction

  function automatic bit window_ok(longint first, longint lastp);
    logic [31:0] c;
    if (longint'(m_start) + lastp > 64'hFFFFFFFF) return 0;
    if (m_unmapped != 0) return 0;
    if (m_plen == 0 || m_plen > 16 || m_plen > m_body) return 0;
    for (int i = 0; i < m_plen; i++)
      if (m_store[(first + i) % MAXB][7:0] != prefix_at(i)) return 0;
    c = 32'hFFFFFFFF;
    for (longint p = first; p <= lastp; p++) begin
      c ^= {24'd0, m_store[p % MAXB][7:0]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    end
    return (~c) == m_crc;
  endfunction

  task automatic predict_byte(byte_req_t r);
    longint k;
    bit was_done;
    bit hit;
    was_done = m_done;
    hit = 0;
    if (!m_done && m_seen != 32'hFFFFFFFF) begin
      k = m_seen;
      if (m_body >= 1 && m_body <= MAXB) begin
        if (k >= m_body && m_store[(k - m_body) % MAXB][8] == 1'b0 && m_unmapped > 0)
          m_unmapped--;
        m_store[k % MAXB] = {r.mapped, r.data};
        if (!r.mapped) m_unmapped++;
        if (k + 1 >= m_body && window_ok(k + 1 - m_body, k)) begin
          expected_reports.push_back('{1'b1, m_start + 32'(k + 1 - m_body)});
          hit = 1;
          m_done = 1;
        end
      end
      m_seen = 32'(k + 1);
    end
    if (r.last) begin
      if (!was_done && !hit) expected_reports.push_back('{1'b0, 32'd0});
      m_seen = 0; m_unmapped = 0; m_done = 0;
    end
  endtask

  // Driver: one request per accepted handshake, model updated on acceptance.
  always @(negedge clk) begin
    if (rst_n && in_valid && in_ready_q) begin
      predict_byte(pending_bytes.pop_front());
      bytes_sent++;
    end
    if (!rst_n || (in_valid && !in_ready_q)) begin
    end else if (pending_bytes.size() > 0 && $urandom_range(99) >= idle_pct) begin
      in_valid <= 1'b1;
      in_data_byte <= pending_bytes[0].data;
      in_mapped <= pending_bytes[0].mapped;
      in_last_byte <= pending_bytes[0].last;
    end else begin
      in_valid <= 1'b0;
    end
    out_ready <= !hold_out && ($urandom_range(99) >= idle_pct);
  end

  // Handshake samples taken at the rising edge.
  always @(posedge clk) begin
    in_ready_q <= in_valid && in_ready;
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))) watchdog <= 0;
    else if (rst_n) watchdog <= watchdog + 1;
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report found=%0b addr=%h", $time, out_found,
                 out_match_address);
        errors++;
      end else begin
        report_t e;
        e = expected_reports.pop_front();
        if (e.found) found_seen++;
        if (out_found !== e.found) begin
          $display("%0t: found expected %0b actual %0b", $time, e.found, out_found);
          errors++;
        end
        if (out_match_address !== e.addr) begin
          $display("%0t: match_address expected %h actual %h", $time, e.addr,
                   out_match_address);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (watchdog >= WD_LIMIT) begin
      $display("%0t: watchdog expired, %0d reports outstanding", $time,
               expected_reports.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || in_valid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (2 * MAXB + 40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_START_ADDRESS: m_start = val[31:0];
      REG_BODY_LENGTH:   m_body = val[12:0];
      REG_PREFIX_LENGTH: m_plen = val[4:0];
      REG_PREFIX_LOW:    m_plo = val;
      REG_PREFIX_HIGH:   m_phi = val;
      REG_TARGET_CRC:    m_crc = val[31:0];
      default: ;
    endcase
    // Only a defined register restarts the scan.
    if (idx <= REG_TARGET_CRC) begin
      m_seen = 0; m_unmapped = 0; m_done = 0;
    end
  endtask

  function automatic logic [31:0] crc_of(logic [7:0] bytes[$]);
    logic [31:0] c;
    c = 32'hFFFFFFFF;
    foreach (bytes[i]) begin
      c ^= {24'd0, bytes[i]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    end
    return ~c;
  endfunction

  // Sets up a window signature and returns its bytes for planting.
  task automatic program_window(int body, int plen, logic [31:0] start,
                                output logic [7:0] sig[$]);
    logic [63:0] lo, hi;
    sig = {};
    for (int i = 0; i < body; i++) sig.push_back(8'($urandom));
    lo = '0; hi = '0;
    for (int i = 0; i < 16; i++) begin
      if (i < 8) lo[8*i +: 8] = (i < body) ? sig[i] : 8'($urandom);
      else hi[8*(i-8) +: 8] = (i < body) ? sig[i] : 8'($urandom);
    end
    write_reg(REG_START_ADDRESS, {32'($urandom), start});
    write_reg(REG_BODY_LENGTH, 64'(body));
    write_reg(REG_PREFIX_LENGTH, 64'(plen));
    write_reg(REG_PREFIX_LOW, lo);
    write_reg(REG_PREFIX_HIGH, hi);
    write_reg(REG_TARGET_CRC, {32'($urandom), crc_of(sig)});
  endtask

  // A region of n random bytes with the signature planted at offset at (-1: none).
  task automatic queue_region(int n, logic [7:0] sig[$], int at, int unmap_pct);
    for (int i = 0; i < n; i++) begin
      byte_req_t r;
      r.data = 8'($urandom);
      if (at >= 0 && i >= at && i < at + sig.size()) r.data = sig[i - at];
      r.mapped = ($urandom_range(99) >= unmap_pct);
      r.last = (i == n - 1);
      pending_bytes.push_back(r);
    end
  endtask

  initial begin
    logic [7:0] sig[$];
    int body, plen, n, at;
    m_start = 0; m_body = 1; m_plen = 1; m_plo = 0; m_phi = 0; m_crc = 0;
    m_seen = 0; m_unmapped = 0; m_done = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: one-byte body at reset settings, all-ones bytes, unmapped bytes.
    pending_bytes.push_back('{8'h00, 1'b1, 1'b1});
    pending_bytes.push_back('{8'hFF, 1'b0, 1'b0});
    pending_bytes.push_back('{8'hFF, 1'b1, 1'b1});
    wait_drained();
    // Match at top of address space and a window that would run past it.
    program_window(4, 4, 32'hFFFFFFFC, sig);
    queue_region(4, sig, 0, 0);
    queue_region(6, sig, 2, 0);
    wait_drained();
    // Prefix longer than body, then region shorter than body.
    program_window(3, 16, 32'h0, sig);
    queue_region(5, sig, 0, 0);
    wait_drained();
    program_window(8, 2, 32'h1000, sig);
    queue_region(5, sig, 0, 0);
    // A region of noise bytes, then one byte left open without a last flag.
    queue_region(4, sig, -1, 0);
    pending_bytes.push_back('{sig[0], 1'b1, 1'b0});
    wait_drained();
    write_reg(REG_UNUSED, 64'hDEAD);     // unused index: no effect
    write_reg(REG_BODY_LENGTH, 64'd0);
    queue_region(4, sig, -1, 0);
    wait_drained();
    program_window(200, 16, 32'h8000_0000, sig);
    queue_region(203, sig, 2, 0);
    wait_drained();

    // Random phases: mostly planted signatures, some noise.
    while (bytes_sent < 1200) begin
      idle_pct = ($urandom_range(3) == 0) ? 0 : 20;
      body = ($urandom_range(7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      plen = $urandom_range(1, 16);
      if (plen > body && $urandom_range(3) != 0) plen = body;
      program_window(body, plen, $urandom, sig);
      for (int reg_i = 0; reg_i < 4; reg_i++) begin
        n = $urandom_range(1, 3 * body + 8);
        at = ($urandom_range(3) == 0 || n < body) ? -1 : $urandom_range(0, n - body);
        queue_region(n, sig, at, ($urandom_range(3) == 0) ? 10 : 0);
      end
      if ($urandom_range(4) == 0) begin
        // Receiver holds off while bytes keep coming, so the unit backs up.
        hold_out = 1'b1;
        repeat (300) @(posedge clk);
        hold_out = 1'b0;
      end
      wait_drained();
    end
    wait_drained();
    $display("Sent %0d bytes, checked %0d reports (%0d matches) across settings.",
             bytes_sent, reports_seen, found_seen);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/core/pcws_pkg.sv
rtl/core/pcws_queue.sv
rtl/core/pcws_front.sv
rtl/core/pcws_back.sv
rtl/core/prefix_and_crc32_window_search_unit.sv
dv/prefix_and_crc32_window_search_unit_tb.sv
